>>> sv/lkv_pkg.sv
// ----------------------------------------------------------------------------
// lkv_pkg
// Shared sizes, types and codes for the LRU key-value cache.
// ----------------------------------------------------------------------------
package lkv_pkg;

    localparam int NUM_ENTRIES = 16;
    localparam int IDX_W       = $clog2(NUM_ENTRIES);
    localparam int CNT_W       = $clog2(NUM_ENTRIES + 1);
    localparam int WORD_W      = 32;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic [IDX_W-1:0]         t_idx;
    typedef logic [CNT_W-1:0]         t_cnt;

    localparam logic  CMD_LOOKUP = 1'b0;
    localparam logic  CMD_STORE  = 1'b1;
    localparam t_word MISS_VALUE = '1;   // -1

    // state update decided for one item
    typedef struct packed {
        logic promote;   // move slot to most recent
        logic fill;      // slot was free, now taken
        logic evict;     // slot held the least recent entry
        logic wr_key;
        logic wr_val;
        t_idx slot;
        t_cnt limit;     // valid entries with rank below this age by one
    } t_upd;

    // one result item
    typedef struct packed {
        logic  hit;
        t_word read_value;
        logic  evicted;
        t_word evicted_key;
    } t_res;

endpackage

>>> sv/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative 16-entry key-value cache with LRU replacement.
// ----------------------------------------------------------------------------
// Usage
//  Input channel  : i_valid / o_stall, fields i_command, i_lookup_key,
//                   i_store_value. A transfer happens on a rising edge with
//                   i_valid high and o_stall low.
//  Output channel : o_valid / i_stall, fields o_hit, o_read_value,
//                   o_evicted, o_evicted_key. One result per input item.
//  Config channel : i_cfg_valid / o_cfg_ready with i_cfg_capacity_in_use.
//                   A transfer sets the capacity and empties the cache; only
//                   issue it while no item is in flight.
//  Path           : an item goes through the input register, then the result
//                   register, before its result is on the output.
//  Throughput     : one item per cycle unless i_stall holds a result. All keys
//                   are compared in parallel and ranks updated in the same
//                   cycle, between the input register and the result register.
//  Stall          : while i_stall holds a result, a second item can still
//                   sit in the input register; o_stall rises only when both
//                   are full, so the result register acts as the skid stage.
//  Reset          : synchronous, active low. Cache emptied, capacity 16,
//                   both pipeline stages empty.
// ----------------------------------------------------------------------------
module lru_key_value_cache (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input items
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_command,
    input  logic signed [31:0]   i_lookup_key,
    input  logic signed [31:0]   i_store_value,
    // results
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_hit,
    output logic signed [31:0]   o_read_value,
    output logic                 o_evicted,
    output logic signed [31:0]   o_evicted_key,
    // configuration
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [4:0]           i_cfg_capacity_in_use
);
    import lkv_pkg::*;

    // input register
    logic  r_in_vld;
    logic  r_in_cmd;
    t_word r_in_key;
    t_word r_in_val;

    // result register
    logic  r_out_vld;
    t_res  r_res;

    // capacity register
    t_cnt  r_cap;
    t_cnt  eff_cap;

    logic  advance;     // input stage may move into result stage
    logic  process;     // item in the input stage is executed this cycle
    logic  in_xfer;
    logic  cfg_xfer;

    t_word [NUM_ENTRIES-1:0] keys;
    t_word [NUM_ENTRIES-1:0] values;
    logic  [NUM_ENTRIES-1:0] valid;
    t_idx  [NUM_ENTRIES-1:0] ranks;
    t_cnt                    held;
    t_upd                    upd;
    t_res                    res;

    assign advance     = !r_out_vld || !i_stall;
    assign process     = r_in_vld && advance;
    assign o_stall     = r_in_vld && !advance;
    assign in_xfer     = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;
    assign cfg_xfer    = i_cfg_valid && o_cfg_ready;

    // zero behaves as one, anything above the entry count saturates
    always_comb begin
        priority if (r_cap == '0) begin
            eff_cap = CNT_W'(1);
        end else if (r_cap > CNT_W'(NUM_ENTRIES)) begin
            eff_cap = CNT_W'(NUM_ENTRIES);
        end else begin
            eff_cap = r_cap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CNT_W'(NUM_ENTRIES);
        end else if (cfg_xfer) begin
            r_cap <= CNT_W'(i_cfg_capacity_in_use);
        end
    end

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_xfer) begin
            r_in_vld <= 1'b1;
        end else if (advance) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_cmd <= i_command;
            r_in_key <= i_lookup_key;
            r_in_val <= i_store_value;
        end
    end

    lkv_lookup u_lookup (
        .i_command (r_in_cmd),
        .i_key     (r_in_key),
        .i_keys    (keys),
        .i_values  (values),
        .i_valid   (valid),
        .i_ranks   (ranks),
        .i_held    (held),
        .i_cap     (eff_cap),
        .o_upd     (upd),
        .o_res     (res)
    );

    lkv_entries u_entries (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (cfg_xfer),
        .i_en     (process),
        .i_upd    (upd),
        .i_key    (r_in_key),
        .i_value  (r_in_val),
        .o_keys   (keys),
        .o_values (values),
        .o_valid  (valid),
        .o_ranks  (ranks),
        .o_held   (held)
    );

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (process) begin
            r_res <= res;
        end
    end

    assign o_valid       = r_out_vld;
    assign o_hit         = r_res.hit;
    assign o_read_value  = r_res.read_value;
    assign o_evicted     = r_res.evicted;
    assign o_evicted_key = r_res.evicted_key;

endmodule

>>> sv/lkv_lookup.sv
// ----------------------------------------------------------------------------
// lkv_lookup
// Parallel key match, free/LRU slot search and result selection.
// ----------------------------------------------------------------------------
module lkv_lookup (
    input  logic                                        i_command,
    input  lkv_pkg::t_word                              i_key,
    input  lkv_pkg::t_word [lkv_pkg::NUM_ENTRIES-1:0]   i_keys,
    input  lkv_pkg::t_word [lkv_pkg::NUM_ENTRIES-1:0]   i_values,
    input  logic           [lkv_pkg::NUM_ENTRIES-1:0]   i_valid,
    input  lkv_pkg::t_idx  [lkv_pkg::NUM_ENTRIES-1:0]   i_ranks,
    input  lkv_pkg::t_cnt                               i_held,
    input  lkv_pkg::t_cnt                               i_cap,
    output lkv_pkg::t_upd                               o_upd,
    output lkv_pkg::t_res                               o_res
);
    import lkv_pkg::*;

    logic hit;
    logic has_free;
    logic has_lru;
    logic room;
    logic is_store;
    t_idx hit_idx;
    t_idx free_idx;
    t_idx lru_idx;
    t_cnt held_m1;

    assign is_store = (i_command == CMD_STORE);
    assign room     = (i_held < i_cap);
    assign held_m1  = i_held - CNT_W'(1);

    // lowest matching index wins (keys are unique among valid entries anyway)
    always_comb begin
        hit      = 1'b0;
        hit_idx  = '0;
        has_free = 1'b0;
        free_idx = '0;
        has_lru  = 1'b0;
        lru_idx  = '0;
        for (int i = NUM_ENTRIES - 1; i >= 0; i--) begin
            if (i_valid[i] && (i_keys[i] == i_key)) begin
                hit     = 1'b1;
                hit_idx = IDX_W'(i);
            end
            if (!i_valid[i]) begin
                has_free = 1'b1;
                free_idx = IDX_W'(i);
            end
            if (i_valid[i] && (CNT_W'(i_ranks[i]) == held_m1)) begin
                has_lru = 1'b1;
                lru_idx = IDX_W'(i);
            end
        end
    end

    always_comb begin
        o_upd = '0;
        priority if (hit) begin
            o_upd.promote = 1'b1;
            o_upd.wr_val  = is_store;
            o_upd.slot    = hit_idx;
            o_upd.limit   = CNT_W'(i_ranks[hit_idx]);
        end else if (is_store && room && has_free) begin
            o_upd.promote = 1'b1;
            o_upd.fill    = 1'b1;
            o_upd.wr_key  = 1'b1;
            o_upd.wr_val  = 1'b1;
            o_upd.slot    = free_idx;
            o_upd.limit   = i_held + CNT_W'(1);
        end else if (is_store && (i_held != '0) && has_lru) begin
            o_upd.promote = 1'b1;
            o_upd.evict   = 1'b1;
            o_upd.wr_key  = 1'b1;
            o_upd.wr_val  = 1'b1;
            o_upd.slot    = lru_idx;
            o_upd.limit   = held_m1;
        end else begin
            o_upd = '0;
        end
    end

    always_comb begin
        o_res.hit         = hit;
        o_res.read_value  = (hit && !is_store) ? i_values[hit_idx] : MISS_VALUE;
        o_res.evicted     = o_upd.evict;
        o_res.evicted_key = o_upd.evict ? i_keys[lru_idx] : '0;
    end

endmodule

>>> sv/lkv_entries.sv
// ----------------------------------------------------------------------------
// lkv_entries
// Entry storage: keys, values, valid bits, recency ranks and fill count.
// ----------------------------------------------------------------------------
module lkv_entries (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_clear,
    input  logic                                        i_en,
    input  lkv_pkg::t_upd                               i_upd,
    input  lkv_pkg::t_word                              i_key,
    input  lkv_pkg::t_word                              i_value,
    output lkv_pkg::t_word [lkv_pkg::NUM_ENTRIES-1:0]   o_keys,
    output lkv_pkg::t_word [lkv_pkg::NUM_ENTRIES-1:0]   o_values,
    output logic           [lkv_pkg::NUM_ENTRIES-1:0]   o_valid,
    output lkv_pkg::t_idx  [lkv_pkg::NUM_ENTRIES-1:0]   o_ranks,
    output lkv_pkg::t_cnt                               o_held
);
    import lkv_pkg::*;

    t_word [NUM_ENTRIES-1:0] r_keys;
    t_word [NUM_ENTRIES-1:0] r_values;
    logic  [NUM_ENTRIES-1:0] r_valid;
    t_idx  [NUM_ENTRIES-1:0] r_ranks;
    t_cnt                    r_held;

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_en && i_upd.wr_key) begin
            r_keys[i_upd.slot] <= i_key;
        end
        if (i_en && i_upd.wr_val) begin
            r_values[i_upd.slot] <= i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_valid <= '0;
            r_ranks <= '0;
            r_held  <= '0;
        end else if (i_en && i_upd.promote) begin
            for (int i = 0; i < NUM_ENTRIES; i++) begin
                if (IDX_W'(i) == i_upd.slot) begin
                    r_ranks[i] <= '0;
                end else if (r_valid[i] && (CNT_W'(r_ranks[i]) < i_upd.limit)) begin
                    r_ranks[i] <= r_ranks[i] + IDX_W'(1);
                end
            end
            if (i_upd.fill) begin
                r_valid[i_upd.slot] <= 1'b1;
                r_held              <= r_held + CNT_W'(1);
            end
        end
    end

    assign o_keys   = r_keys;
    assign o_values = r_values;
    assign o_valid  = r_valid;
    assign o_ranks  = r_ranks;
    assign o_held   = r_held;

endmodule

>>> sv/lkv_checker.sv
// ----------------------------------------------------------------------------
// lkv_checker
// Port-level checks for the LRU key-value cache, bound to the top level.
// ----------------------------------------------------------------------------
module lkv_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_stall,
    input logic                 o_valid,
    input logic                 i_stall,
    input logic                 o_hit,
    input logic signed [31:0]   o_read_value,
    input logic                 o_evicted,
    input logic signed [31:0]   o_evicted_key
);

    // pipeline empty straight after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (!o_valid && !o_stall))
        else $error("output valid or input stall after reset");

    // a hit never evicts
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_hit && o_evicted))
        else $error("hit and eviction reported together");

    // miss returns -1, no eviction means zero key
    a_miss_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hit) |-> ((o_read_value == '1)
                                 && (o_evicted || (o_evicted_key == '0))))
        else $error("miss value or evicted key wrong");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_hit) && $stable(o_read_value)
                                  && $stable(o_evicted) && $stable(o_evicted_key)))
        else $error("stalled result changed");

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_hit         (o_hit),
    .o_read_value  (o_read_value),
    .o_evicted     (o_evicted),
    .o_evicted_key (o_evicted_key)
);
